@@ hdl/q8bd_pkg.sv @@
package q8bd_pkg;

	localparam int LANES      = 4;
	localparam int LANE_ELEMS = 8;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] FP_INF    = 32'h7F80_0000;

	typedef logic [31:0] fp32_t;

	// one lane sums eight int8 products: |sum| <= 8 * 16384
	typedef logic signed [18:0] lane_sum_t;
	// four lanes: |dot| <= 32 * 16384
	typedef logic signed [20:0] dot_t;

	// operand class that bypasses the normal datapath
	typedef enum logic [1:0] {
		FC_NONE,
		FC_ZERO,
		FC_INF,
		FC_NAN
	} fp_class_t;

	function automatic logic fp_is_nan(input fp32_t x);
		fp_is_nan = (&x[30:23]) && (|x[22:0]);
	endfunction

endpackage

@@ hdl/q8bd_if.sv @@
interface q8bd_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] weight_bytes_a;
	logic [63:0] weight_bytes_b;
	logic [63:0] weight_bytes_c;
	logic [63:0] weight_bytes_d;
	logic [63:0] act_bytes_a;
	logic [63:0] act_bytes_b;
	logic [63:0] act_bytes_c;
	logic [63:0] act_bytes_d;
	logic [15:0] weight_scale;
	logic [31:0] act_scale;
	logic        last;

	modport source (
		output valid, weight_bytes_a, weight_bytes_b, weight_bytes_c, weight_bytes_d,
		output act_bytes_a, act_bytes_b, act_bytes_c, act_bytes_d,
		output weight_scale, act_scale, last,
		input  ready
	);
	modport sink (
		input  valid, weight_bytes_a, weight_bytes_b, weight_bytes_c, weight_bytes_d,
		input  act_bytes_a, act_bytes_b, act_bytes_c, act_bytes_d,
		input  weight_scale, act_scale, last,
		output ready
	);
endinterface

interface q8bd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] sum_bits;

	modport source (output valid, sum_bits, input ready);
	modport sink (input valid, sum_bits, output ready);
endinterface

@@ hdl/q8bd_lane.sv @@
module q8bd_lane
	import q8bd_pkg::*;
(
	input  logic        clk,
	input  logic [63:0] w,
	input  logic [63:0] a,
	output lane_sum_t   sum_s1
);

	lane_sum_t acc;

	// multiply eight signed byte pairs and add them up
	always_comb begin
		logic signed [15:0] prod;
		acc = '0;
		for (int i = 0; i < LANE_ELEMS; i++) begin
			prod = $signed(w[8*i +: 8]) * $signed(a[8*i +: 8]);
			acc  = acc + lane_sum_t'(prod);
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= acc;
	end

endmodule

@@ hdl/q8bd_merge.sv @@
module q8bd_merge
	import q8bd_pkg::*;
(
	input  logic                  clk,
	input  lane_sum_t [LANES-1:0] lane_sums,
	input  logic [15:0]           weight_scale,
	output fp32_t                 dw,
	output fp32_t                 fdot
);

	dot_t  dot_s1;
	fp32_t dw_s1;
	fp32_t fdot_s2;

	function automatic logic [3:0] lead10(input logic [9:0] x);
		lead10 = '0;
		for (int i = 0; i < 10; i++) begin
			if (x[i]) lead10 = 4'(i);
		end
	endfunction

	function automatic logic [4:0] lead20(input logic [19:0] x);
		lead20 = '0;
		for (int i = 0; i < 20; i++) begin
			if (x[i]) lead20 = 5'(i);
		end
	endfunction

	dot_t        dot_sum;
	fp32_t       dw_c;
	logic [3:0]  hp;
	logic [10:0] hman_sh;

	// add the lanes; widen the half scale exactly
	always_comb begin
		dot_sum = '0;
		for (int i = 0; i < LANES; i++) begin
			dot_sum = dot_sum + dot_t'(lane_sums[i]);
		end

		hp      = lead10(weight_scale[9:0]);
		hman_sh = {1'b0, weight_scale[9:0]} << (4'd10 - hp);
		if (weight_scale[14:10] == 5'd0) begin
			if (weight_scale[9:0] == 10'd0) begin
				dw_c = {weight_scale[15], 31'd0};
			end else begin
				dw_c = {weight_scale[15], 8'd103 + {4'd0, hp}, hman_sh[9:0], 13'd0};
			end
		end else if (weight_scale[14:10] == 5'h1F) begin
			dw_c = {weight_scale[15], 8'hFF, weight_scale[9:0], 13'd0};
		end else begin
			dw_c = {weight_scale[15], {3'd0, weight_scale[14:10]} + 8'd112,
				weight_scale[9:0], 13'd0};
		end
	end

	always_ff @(posedge clk) begin
		dot_s1 <= dot_sum;
		dw_s1  <= dw_c;
	end

	logic [20:0] mag_w;
	logic [19:0] mag;
	logic [4:0]  dp;
	logic [42:0] dman_sh;
	fp32_t       fdot_c;

	// convert the dot to fp32, exact since |dot| <= 2^19
	always_comb begin
		mag_w   = dot_s1[20] ? 21'(-dot_s1) : 21'(dot_s1);
		mag     = mag_w[19:0];
		dp      = lead20(mag);
		dman_sh = {23'd0, mag} << (5'd23 - dp);
		if (mag == 20'd0) begin
			fdot_c = '0;
		end else begin
			fdot_c = {dot_s1[20], 8'd127 + {3'd0, dp}, dman_sh[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		fdot_s2 <= fdot_c;
	end

	assign dw   = dw_s1;
	assign fdot = fdot_s2;

endmodule

@@ hdl/q8bd_fmul.sv @@
module q8bd_fmul
	import q8bd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  fp32_t a,
	input  fp32_t b,
	output logic  done,
	output fp32_t y
);

	logic vld_s1, vld_s2, vld_s3;

	logic [47:0]        prod_s1, prod_s2;
	logic [8:0]         esum_s1, esum_s2;
	logic               sign_s1, sign_s2;
	fp_class_t          cls_s1, cls_s2;
	logic signed [10:0] shamt_s2;
	fp32_t              y_s3;

	function automatic logic [5:0] lead48(input logic [47:0] x);
		lead48 = '0;
		for (int i = 0; i < 48; i++) begin
			if (x[i]) lead48 = 6'(i);
		end
	endfunction

	// advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	logic      a_zero, b_zero, a_inf, b_inf;
	fp_class_t cls_c;

	// classify operands
	always_comb begin
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		a_inf  = (a[30:0] == FP_INF[30:0]);
		b_inf  = (b[30:0] == FP_INF[30:0]);
		if (fp_is_nan(a) || fp_is_nan(b) || (a_inf && b_zero) || (a_zero && b_inf)) begin
			cls_c = FC_NAN;
		end else if (a_inf || b_inf) begin
			cls_c = FC_INF;
		end else if (a_zero || b_zero) begin
			cls_c = FC_ZERO;
		end else begin
			cls_c = FC_NONE;
		end
	end

	// stage 1: significand product and exponent sum
	always_ff @(posedge clk) begin
		prod_s1 <= {(a[30:23] != 8'd0), a[22:0]} * {(b[30:23] != 8'd0), b[22:0]};
		esum_s1 <= {1'b0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}
			+ {1'b0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]};
		sign_s1 <= a[31] ^ b[31];
		cls_s1  <= cls_c;
	end

	logic signed [10:0] sh_norm, sh_sub;

	// stage 2: pick the shift that puts the unit in the last place
	always_comb begin
		sh_norm = $signed({5'd0, lead48(prod_s1)}) - 11'sd23;
		sh_sub  = 11'sd151 - $signed({2'd0, esum_s1});
	end

	always_ff @(posedge clk) begin
		prod_s2  <= prod_s1;
		esum_s2  <= esum_s1;
		sign_s2  <= sign_s1;
		cls_s2   <= cls_s1;
		shamt_s2 <= (sh_norm > sh_sub) ? sh_norm : sh_sub;
	end

	logic [10:0] neg_sh;
	logic [5:0]  sc;
	logic [47:0] shl, shr, gbits;
	logic [23:0] q;
	logic        g, st;
	logic [24:0] qr;
	logic [11:0] tx;
	logic [32:0] wide;
	fp32_t       y_c;

	// stage 3: shift, round to nearest even, pack
	always_comb begin
		neg_sh = 11'(-shamt_s2);
		sc     = (shamt_s2 > 11'sd49) ? 6'd49 : shamt_s2[5:0];
		shl    = prod_s2 << neg_sh[4:0];
		shr    = prod_s2 >> sc;
		gbits  = prod_s2 >> (sc - 6'd1);
		if (shamt_s2 <= 11'sd0) begin
			q  = shl[23:0];
			g  = 1'b0;
			st = 1'b0;
		end else begin
			q  = shr[23:0];
			g  = gbits[0];
			st = |(prod_s2 & ~({48{1'b1}} << (sc - 6'd1)));
		end
		qr   = {1'b0, q} + {24'd0, g & (st | q[0])};
		tx   = {shamt_s2[10], shamt_s2} + {3'd0, esum_s2} - 12'd151;
		wide = {tx[9:0], 23'd0} + {8'd0, qr};

		case (cls_s2)
			FC_NAN:  y_c = CANON_NAN;
			FC_INF:  y_c = {sign_s2, FP_INF[30:0]};
			FC_ZERO: y_c = {sign_s2, 31'd0};
			default: begin
				if (wide[32:23] >= 10'd255) begin
					y_c = {sign_s2, FP_INF[30:0]};
				end else begin
					y_c = {sign_s2, wide[30:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		y_s3 <= y_c;
	end

	assign done = vld_s3;
	assign y    = y_s3;

endmodule

@@ hdl/q8bd_fadd.sv @@
module q8bd_fadd
	import q8bd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  fp32_t a,
	input  fp32_t b,
	output logic  done,
	output fp32_t y
);

	logic vld_s1, vld_s2;

	logic [27:0] sum_s1;
	logic [7:0]  eb_s1;
	logic        sign_s1, zsign_s1;
	fp_class_t   cls_s1;
	fp32_t       y_s2;

	function automatic logic [4:0] lead27(input logic [26:0] x);
		lead27 = '0;
		for (int i = 0; i < 27; i++) begin
			if (x[i]) lead27 = 5'(i);
		end
	endfunction

	// advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	fp32_t       big, sml;
	logic [7:0]  eb, es, d;
	logic [4:0]  dc;
	logic [26:0] mbig, msml, mal;
	logic        stk, sub;
	logic [27:0] sum_c;
	fp_class_t   cls_c;

	// stage 1: order by magnitude, align, add or subtract
	always_comb begin
		if (b[30:0] > a[30:0]) begin
			big = b;
			sml = a;
		end else begin
			big = a;
			sml = b;
		end
		eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d    = eb - es;
		dc   = (d > 8'd27) ? 5'd27 : d[4:0];
		mbig = {(big[30:23] != 8'd0), big[22:0], 3'd0};
		msml = {(sml[30:23] != 8'd0), sml[22:0], 3'd0};
		stk  = |(msml & ~({27{1'b1}} << dc));
		mal  = (msml >> dc) | {26'd0, stk};
		sub  = a[31] ^ b[31];
		sum_c = sub ? ({1'b0, mbig} - {1'b0, mal}) : ({1'b0, mbig} + {1'b0, mal});

		if (fp_is_nan(a) || fp_is_nan(b)) begin
			cls_c = FC_NAN;
		end else if (big[30:0] == FP_INF[30:0]) begin
			cls_c = (sub && sml[30:0] == FP_INF[30:0]) ? FC_NAN : FC_INF;
		end else begin
			cls_c = FC_NONE;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1   <= sum_c;
		eb_s1    <= eb;
		sign_s1  <= big[31];
		zsign_s1 <= sub ? 1'b0 : big[31];
		cls_s1   <= cls_c;
	end

	logic [4:0]  lz, lim, k;
	logic [26:0] n;
	logic [8:0]  tx;
	logic [23:0] q;
	logic        g, st;
	logic [24:0] qr;
	logic [32:0] wide;
	fp32_t       y_c;

	// stage 2: normalize, stop at the subnormal range, round, pack
	always_comb begin
		lz  = 5'd26 - lead27(sum_s1[26:0]);
		lim = (eb_s1 - 8'd1 > 8'd26) ? 5'd26 : 5'(eb_s1 - 8'd1);
		k   = (lz < lim) ? lz : lim;
		if (sum_s1[27]) begin
			n  = {sum_s1[27:2], sum_s1[1] | sum_s1[0]};
			tx = {1'b0, eb_s1};
		end else begin
			n  = sum_s1[26:0] << k;
			tx = {1'b0, eb_s1} - 9'd1 - {4'd0, k};
		end
		q    = n[26:3];
		g    = n[2];
		st   = n[1] | n[0];
		qr   = {1'b0, q} + {24'd0, g & (st | q[0])};
		wide = {1'b0, tx, 23'd0} + {8'd0, qr};

		case (cls_s1)
			FC_NAN: y_c = CANON_NAN;
			FC_INF: y_c = {sign_s1, FP_INF[30:0]};
			default: begin
				if (sum_s1 == 28'd0) begin
					y_c = {zsign_s1, 31'd0};
				end else if (wide[32:23] >= 10'd255) begin
					y_c = {sign_s1, FP_INF[30:0]};
				end else begin
					y_c = {sign_s1, wide[30:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		y_s2 <= y_c;
	end

	assign done = vld_s2;
	assign y    = y_s2;

endmodule

@@ hdl/q8_block_dot_accumulate.sv @@
// A new item is taken only after the previous one is done; each item makes two passes
// through the shared three-stage fp32 multiplier, then one through the two-stage adder
// that closes the running sum. Four lanes form the 32-term integer dot product.
// Reset (arst_n low, asynchronous) clears the running sum to +0 and drops all valids.
module q8_block_dot_accumulate
	import q8bd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	q8bd_in_if.sink           items,
	q8bd_out_if.source        sums
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOT,
		ST_MERGE,
		ST_CVT,
		ST_MUL1,
		ST_MUL2,
		ST_ADD,
		ST_WB
	} state_t;

	state_t state_q;

	logic [63:0] w_q [LANES];
	logic [63:0] a_q [LANES];
	logic [15:0] wscale_q;
	fp32_t       ascale_q;
	logic        last_q;

	fp32_t sum_q;
	fp32_t res_q;
	fp32_t out_q;
	logic  out_vld_q;

	logic accept;
	assign accept      = items.valid && items.ready;
	assign items.ready = (state_q == ST_IDLE);

	// hold the item for the whole computation
	always_ff @(posedge clk) begin
		if (accept) begin
			w_q[0]   <= items.weight_bytes_a;
			w_q[1]   <= items.weight_bytes_b;
			w_q[2]   <= items.weight_bytes_c;
			w_q[3]   <= items.weight_bytes_d;
			a_q[0]   <= items.act_bytes_a;
			a_q[1]   <= items.act_bytes_b;
			a_q[2]   <= items.act_bytes_c;
			a_q[3]   <= items.act_bytes_d;
			wscale_q <= items.weight_scale;
			ascale_q <= items.act_scale;
			last_q   <= items.last;
		end
	end

	lane_sum_t [LANES-1:0] lane_sums;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		q8bd_lane u_lane (
			.clk    (clk),
			.w      (w_q[i]),
			.a      (a_q[i]),
			.sum_s1 (lane_sums[i])
		);
	end

	fp32_t dw, fdot;

	q8bd_merge u_merge (
		.clk          (clk),
		.lane_sums    (lane_sums),
		.weight_scale (wscale_q),
		.dw           (dw),
		.fdot         (fdot)
	);

	// the multiplier runs twice: scale product, then times the dot
	logic  mul_start, mul_done;
	fp32_t mul_a, mul_b, mul_y;

	assign mul_start = (state_q == ST_CVT) || (state_q == ST_MUL1 && mul_done);
	assign mul_a     = (state_q == ST_CVT) ? dw : mul_y;
	assign mul_b     = (state_q == ST_CVT) ? ascale_q : fdot;

	q8bd_fmul u_fmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.y      (mul_y)
	);

	logic  add_start, add_done;
	fp32_t add_y;

	assign add_start = (state_q == ST_MUL2) && mul_done;

	q8bd_fadd u_fadd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (add_start),
		.a      (sum_q),
		.b      (mul_y),
		.done   (add_done),
		.y      (add_y)
	);

	// load the result register when the last beat finishes and the slot is free
	logic emit;
	assign emit = (state_q == ST_WB) && last_q && (!out_vld_q || sums.ready);

	// sequence one item through the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			res_q     <= '0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (sums.valid && sums.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_DOT;
				end
				ST_DOT:   state_q <= ST_MERGE;
				ST_MERGE: state_q <= ST_CVT;
				ST_CVT:   state_q <= ST_MUL1;
				ST_MUL1: begin
					if (mul_done) state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					if (mul_done) state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (add_done) begin
						res_q   <= add_y;
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (!last_q) begin
						sum_q   <= res_q;
						state_q <= ST_IDLE;
					end else if (emit) begin
						out_q   <= fp_is_nan(res_q) ? CANON_NAN : res_q;
						sum_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sums.valid    = out_vld_q;
	assign sums.sum_bits = out_q;

endmodule

@@ hdl/q8bd_chk.sv @@
module q8bd_chk
	import q8bd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] sum_bits
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum_bits))
		else $error("stalled result beat changed");

	// stay busy after taking a beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input taken while an item is in flight");

	// a new result appears only while an item is being finished
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without an item in flight");

	// emit NaN only in canonical form
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (&sum_bits[30:23]) && (|sum_bits[22:0]) |-> sum_bits == CANON_NAN)
		else $error("non-canonical NaN on output");

endmodule

bind q8_block_dot_accumulate q8bd_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (sums.valid),
	.out_ready (sums.ready),
	.sum_bits  (sums.sum_bits)
);
